// File: design/u8u16_pkg.sv
package u8u16_pkg;

  // Lead byte ranges
  localparam logic [7:0] LeadMin2  = 8'hC2;
  localparam logic [7:0] LeadMin3  = 8'hE0;
  localparam logic [7:0] LeadMin4  = 8'hF0;
  localparam logic [7:0] LeadMax   = 8'hF4;
  localparam logic [7:0] AsciiLim  = 8'h80;
  localparam logic [1:0] ContTag   = 2'b10;

  // Overlong / range limits on the payload after two bytes
  localparam logic [20:0] Min3Byte = 21'h20;
  localparam logic [20:0] Min4Byte = 21'h10;
  localparam logic [20:0] Max4Byte = 21'h10F;

  // Surrogate and plane limits
  localparam logic [20:0] SurrLo   = 21'h0D800;
  localparam logic [20:0] SurrHi   = 21'h0E000;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [15:0] HighBase = 16'hD800;
  localparam logic [15:0] LowBase  = 16'hDC00;

  // Result status codes
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  // Output queue depth
  localparam int QDepth = 4;
  localparam int QAw    = 2;
  localparam int QCw    = 3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [14:0] partial_bits;
    logic [1:0]  bytes_needed;
    logic [1:0]  seq_length;
  } seq_t;

  typedef struct packed {
    logic [1:0] n_res;
    res_t       res0;
    res_t       res1;
    seq_t       seq_next;
  } dec_t;

endpackage

// File: design/u8u16_decode.sv
module u8u16_decode (
  input  u8u16_pkg::seq_t seq,
  input  logic [7:0]      in_byte,
  input  logic            clear_partial,
  output u8u16_pkg::dec_t dec
);

  u8u16_pkg::seq_t   cur;
  logic [20:0]       cp;
  logic [20:0]       v;
  logic [1:0]        need;
  logic              range_bad;
  u8u16_pkg::res_t   err_res;
  u8u16_pkg::seq_t   idle_seq;

  // Effective state after an optional discard
  always_comb begin
    cur = clear_partial ? '0 : seq;
  end

  assign cp   = {cur.partial_bits, in_byte[5:0]};
  assign v    = cp - u8u16_pkg::SuppBase;
  assign need = cur.bytes_needed - 2'd1;
  assign err_res  = '{code_unit: 16'h0000, status: u8u16_pkg::StatusErr, last: 1'b1};
  assign idle_seq = '0;

  // Overlong / out-of-range check on the second byte of a sequence
  always_comb begin
    range_bad = 1'b0;
    if (cur.seq_length == 2'd1) begin
      if (cur.bytes_needed == 2'd2 && cp < u8u16_pkg::Min3Byte) begin
        range_bad = 1'b1;
      end
      if (cur.bytes_needed == 2'd3 &&
          (cp < u8u16_pkg::Min4Byte || cp > u8u16_pkg::Max4Byte)) begin
        range_bad = 1'b1;
      end
    end
  end

  // Per-byte decode
  always_comb begin
    dec.n_res    = 2'd0;
    dec.res0     = err_res;
    dec.res1     = err_res;
    dec.seq_next = cur;
    if (cur.bytes_needed == 2'd0) begin
      if (in_byte < u8u16_pkg::AsciiLim) begin
        dec.n_res = 2'd1;
        dec.res0  = '{code_unit: {8'h00, in_byte}, status: u8u16_pkg::StatusOk,
                      last: 1'b1};
      end else if (in_byte < u8u16_pkg::LeadMin2 || in_byte > u8u16_pkg::LeadMax) begin
        dec.n_res    = 2'd1;
        dec.seq_next = idle_seq;
      end else if (in_byte < u8u16_pkg::LeadMin3) begin
        dec.seq_next = '{partial_bits: {10'd0, in_byte[4:0]}, bytes_needed: 2'd1,
                         seq_length: 2'd1};
      end else if (in_byte < u8u16_pkg::LeadMin4) begin
        dec.seq_next = '{partial_bits: {11'd0, in_byte[3:0]}, bytes_needed: 2'd2,
                         seq_length: 2'd1};
      end else begin
        dec.seq_next = '{partial_bits: {12'd0, in_byte[2:0]}, bytes_needed: 2'd3,
                         seq_length: 2'd1};
      end
    end else if (in_byte[7:6] != u8u16_pkg::ContTag || range_bad) begin
      dec.n_res    = 2'd1;
      dec.seq_next = idle_seq;
    end else if (need != 2'd0) begin
      // Continuation that does not finish the sequence
      dec.seq_next = '{partial_bits: cp[14:0], bytes_needed: need,
                       seq_length: cur.seq_length + 2'd1};
    end else begin
      dec.seq_next = idle_seq;
      dec.n_res    = 2'd1;
      if (cp >= u8u16_pkg::SurrLo && cp < u8u16_pkg::SurrHi) begin
        dec.res0 = err_res;
      end else if (cp >= u8u16_pkg::SuppBase) begin
        // Surrogate pair, last on the low half
        dec.n_res = 2'd2;
        dec.res0  = '{code_unit: u8u16_pkg::HighBase + {6'd0, v[19:10]},
                      status: u8u16_pkg::StatusOk, last: 1'b0};
        dec.res1  = '{code_unit: u8u16_pkg::LowBase + {6'd0, v[9:0]},
                      status: u8u16_pkg::StatusOk, last: 1'b1};
      end else begin
        dec.res0  = '{code_unit: cp[15:0], status: u8u16_pkg::StatusOk, last: 1'b1};
      end
    end
  end

endmodule

// File: design/utf8_to_utf16_decoder_top.sv
// UTF-8 to UTF-16 stream decoder.
//
// Input channel (s_*): one UTF-8 byte per request on s_tdata; s_tuser set
// discards any pending partial sequence before that byte is decoded.
// Output channel (m_*): one UTF-16 code unit per request on m_tdata;
// m_tuser is the status (0 ok, 1 illegal sequence, unit then 0); m_tlast
// marks the final result caused by one input byte. A supplementary code
// point gives a high surrogate (m_tlast 0) then a low surrogate (m_tlast 1).
// Bytes that only extend a sequence give no result.
//
// Each byte is held in the input register and each result is written to the
// result queue before it is offered on m_*.
// Throughput: one byte per cycle while the queue has room. Bytes pass an input
// register, the decode logic, then a 4-entry result queue; the input register
// advances whenever the queue has room for two results after this cycle's pop,
// so a stalled receiver backs up into the queue and then drops s_tready.
//
// Reset (rst, synchronous): clears the partial sequence, the input register
// and the result queue. No results are pending after reset.
module utf8_to_utf16_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] clear_partial
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tuser,   // [0] status
  output logic        m_tlast
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_clr;

  // Sequence state
  u8u16_pkg::seq_t seq;
  u8u16_pkg::dec_t dec;

  // Result queue
  u8u16_pkg::res_t q [u8u16_pkg::QDepth];
  logic [u8u16_pkg::QAw-1:0] wr_ptr;
  logic [u8u16_pkg::QAw-1:0] rd_ptr;
  logic [u8u16_pkg::QCw-1:0] count;
  logic [u8u16_pkg::QCw-1:0] count_next;
  logic [u8u16_pkg::QCw-1:0] after_pop;
  logic                      pop;
  logic                      advance;
  logic [1:0]                push_n;
  u8u16_pkg::res_t           head;

  u8u16_decode u_decode (
    .seq           (seq),
    .in_byte       (s1_byte),
    .clear_partial (s1_clr),
    .dec           (dec)
  );

  // Handshake and queue accounting
  assign pop       = m_tvalid && m_tready;
  assign after_pop = count - {{(u8u16_pkg::QCw-1){1'b0}}, pop};
  assign advance   = s1_valid &&
                     (after_pop <= u8u16_pkg::QCw'(u8u16_pkg::QDepth - 2));
  assign push_n    = advance ? dec.n_res : 2'd0;
  assign count_next = after_pop + {{(u8u16_pkg::QCw-2){1'b0}}, push_n};
  assign s_tready  = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      s1_byte <= s_tdata;
      s1_clr  <= s_tuser;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (advance) begin
      seq <= dec.seq_next;
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {{(u8u16_pkg::QAw-1){1'b0}}, pop};
      count  <= count_next;
    end
    if (push_n != 2'd0) begin
      q[wr_ptr] <= dec.res0;
    end
    if (push_n == 2'd2) begin
      q[wr_ptr + 2'd1] <= dec.res1;
    end
  end

  assign head     = q[rd_ptr];
  assign m_tvalid = (count != '0);
  assign m_tdata  = head.code_unit;
  assign m_tuser  = head.status;
  assign m_tlast  = head.last;

`ifndef ASSERT_OFF
  // Queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= u8u16_pkg::QCw'(u8u16_pkg::QDepth))
    else $error("result queue overflow");

  // Idle sequence state carries no length
  a_seq_consistent: assert property (@(posedge clk) disable iff (rst)
    (seq.bytes_needed == 2'd0) |-> (seq.seq_length == 2'd0))
    else $error("sequence length set while idle");

  // A held input byte is not lost while the queue lacks room for two results
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_byte) && $stable(s1_clr)))
    else $error("pending input byte changed while stalled");

  // First half of a surrogate pair never ends the byte's results
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.n_res == 2'd2) |-> (!dec.res0.last && dec.res1.last))
    else $error("surrogate pair last flags wrong");
`endif

endmodule
